### hw/rtl/bmf_pkg.sv
// shared types and constants for the rgb box mean filter
package bmf_pkg;

   // one input item
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       is_flush;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       last_of_frame;
   } rsp_type;

   // pixel as kept in the line store
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // effective (clamped) configuration
   typedef struct packed {
      logic [2:0]  radius;
      logic [10:0] width;
      logic [10:0] height;
   } cfg_type;

   // window job handed from front to back
   typedef struct packed {
      logic [10:0] row;
      logic [10:0] col;
      logic        last;
   } job_type;

   // back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_DRAIN,
      BK_DIVIDE,
      BK_PUSH
   } back_state_type;

   // register indexes
   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   // register reset values
   localparam logic [2:0]  RST_RADIUS = 3'd1;
   localparam logic [10:0] RST_WIDTH  = 11'd1024;
   localparam logic [10:0] RST_HEIGHT = 11'd1024;

   // datapath sizes: window sum of at most 15x15 pixels, 8 bit quotient
   localparam int SUM_W       = 16;
   localparam int REM_W       = SUM_W + 2;
   localparam int DIV_STEPS   = 8;
   localparam int QUEUE_DEPTH = 2;

endpackage

### hw/rtl/bmf_ram.sv
// generic single write port, single read port ram with registered read
module bmf_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 16384,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/bmf_fifo.sv
// small register fifo used for the job queue and the result queue
module bmf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (32'(count_ff) == DEPTH);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hw/rtl/bmf_front.sv
// front end: takes items, fills the line store, tracks raster position, issues window jobs
module bmf_front #(
   parameter int MAX_RADIUS = 7,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int ADDR_W     = $clog2(2 * MAX_RADIUS + 2) + $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  bmf_pkg::cfg_type    cfg,
   input  logic                restart,
   input  logic                push,
   output logic                full,
   input  bmf_pkg::req_type    item,
   input  logic                job_q_empty,
   input  logic                back_reading,
   output logic                st_we,
   output logic [ADDR_W-1:0]   st_addr,
   output bmf_pkg::pixel_type  st_data,
   output logic                job_push,
   output bmf_pkg::job_type    job
);

   import bmf_pkg::*;

   localparam int RB = $clog2(2 * MAX_RADIUS + 2);
   localparam int CB = ADDR_W - RB;
   localparam int PW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

   logic [PW-1:0] p_ff, p_in;
   logic [10:0]   col_ff, col_in, qr_ff, qr_in, qc_ff, qc_in;
   logic [RB-1:0] row_lo_ff, row_lo_in;
   logic [21:0]   total;
   logic [13:0]   lag;
   logic [31:0]   q;
   logic          accept, in_frame, due, overrun, last, col_wrap, qc_wrap;

   // hold off while a job waits or the back end walks the store
   assign full   = !job_q_empty || back_reading;
   assign accept = push && !full;

   // frame geometry
   assign total    = 22'(cfg.width) * 22'(cfg.height);
   assign lag      = 14'(cfg.radius) * 14'(cfg.width) + 14'(cfg.radius);
   assign in_frame = 32'(p_ff) < 32'(total);
   assign due      = 32'(p_ff) >= 32'(lag);
   assign q        = 32'(p_ff) - 32'(lag);
   assign overrun  = due && (q >= 32'(total));
   assign last     = due && (q == 32'(total) - 32'd1);
   assign col_wrap = (32'(col_ff) + 32'd1) >= 32'(cfg.width);
   assign qc_wrap  = (32'(qc_ff) + 32'd1) >= 32'(cfg.width);

   // line store write, rows kept modulo a power of two
   assign st_we   = accept && in_frame;
   assign st_addr = {row_lo_ff, CB'(col_ff)};
   assign st_data = item.is_flush ? '0 :
                    pixel_type'({item.red_in, item.green_in, item.blue_in});

   // job for the output pixel that just became complete
   assign job_push = accept && due && !overrun;
   assign job      = '{row: qr_ff, col: qc_ff, last: last};

   // position update
   always_comb begin
      p_in      = p_ff;
      col_in    = col_ff;
      row_lo_in = row_lo_ff;
      qr_in     = qr_ff;
      qc_in     = qc_ff;
      if (restart) begin
         p_in      = '0;
         col_in    = '0;
         row_lo_in = '0;
         qr_in     = '0;
         qc_in     = '0;
      end else if (accept) begin
         if (overrun || last) begin
            p_in      = '0;
            col_in    = '0;
            row_lo_in = '0;
            qr_in     = '0;
            qc_in     = '0;
         end else begin
            p_in = p_ff + PW'(1);
            if (col_wrap) begin
               col_in    = '0;
               row_lo_in = row_lo_ff + RB'(1);
            end else begin
               col_in = col_ff + 11'd1;
            end
            if (job_push) begin
               if (qc_wrap) begin
                  qc_in = '0;
                  qr_in = qr_ff + 11'd1;
               end else begin
                  qc_in = qc_ff + 11'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff      <= '0;
         col_ff    <= '0;
         row_lo_ff <= '0;
         qr_ff     <= '0;
         qc_ff     <= '0;
      end else begin
         p_ff      <= p_in;
         col_ff    <= col_in;
         row_lo_ff <= row_lo_in;
         qr_ff     <= qr_in;
         qc_ff     <= qc_in;
      end
   end

endmodule

### hw/rtl/bmf_back.sv
// back end: walks the window through the line store, sums, divides with rounding
module bmf_back #(
   parameter int MAX_RADIUS = 7,
   parameter int MAX_WIDTH  = 1024,
   parameter int ADDR_W     = $clog2(2 * MAX_RADIUS + 2) + $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  bmf_pkg::cfg_type    cfg,
   input  logic                job_q_empty,
   input  bmf_pkg::job_type    job_q_data,
   output logic                job_pop,
   output logic [ADDR_W-1:0]   rd_addr,
   input  bmf_pkg::pixel_type  rd_data,
   input  logic                rsp_full,
   output logic                rsp_push,
   output bmf_pkg::rsp_type    rsp_item,
   output logic                reading
);

   import bmf_pkg::*;

   localparam int RB  = $clog2(2 * MAX_RADIUS + 2);
   localparam int CB  = ADDR_W - RB;
   localparam int RIW = $clog2(2 * MAX_RADIUS + 1);

   back_state_type            state_ff, state_in;
   job_type                   job_ff, job_in;
   logic [RIW-1:0]            dr_ff, dr_in, dc_ff, dc_in, span_last;
   logic                      vld_ff, vld_in;
   logic [2:0][SUM_W-1:0]     acc_ff, acc_in;
   logic [2:0][REM_W-1:0]     rem_ff, rem_in;
   logic [REM_W-1:0]          den_ff, den_in;
   logic [2:0][7:0]           quo_ff, quo_in;
   logic [2:0]                step_ff, step_in;
   logic [2:0][7:0]           rd_ch;
   logic [3:0]                side;
   logic [7:0]                area;
   logic [11:0]               yr_raw, yr, yc_raw, yc;
   logic                      row_ok, col_ok, loop_end, step_last;

   // window geometry
   assign span_last = RIW'({cfg.radius, 1'b0});
   assign side      = {cfg.radius, 1'b1};
   assign area      = 8'(side) * 8'(side);
   assign loop_end  = (dr_ff == span_last) && (dc_ff == span_last);
   assign step_last = (step_ff == 3'(DIV_STEPS - 1));

   // current window tap and its frame bounds
   assign yr_raw  = 12'(job_ff.row) + 12'(dr_ff);
   assign yr      = yr_raw - 12'(cfg.radius);
   assign row_ok  = (yr_raw >= 12'(cfg.radius)) && (yr < 12'(cfg.height));
   assign yc_raw  = 12'(job_ff.col) + 12'(dc_ff);
   assign yc      = yc_raw - 12'(cfg.radius);
   assign col_ok  = (yc_raw >= 12'(cfg.radius)) && (yc < 12'(cfg.width));
   assign rd_addr = {yr[RB-1:0], CB'(yc)};
   assign rd_ch   = rd_data;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (!job_q_empty) state_in = BK_READ;
         BK_READ:   if (loop_end) state_in = BK_DRAIN;
         BK_DRAIN:  state_in = BK_DIVIDE;
         BK_DIVIDE: if (step_last) state_in = BK_PUSH;
         BK_PUSH:   if (!rsp_full) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      job_pop  = 1'b0;
      rsp_push = 1'b0;
      reading  = 1'b0;
      case (state_ff)
         BK_IDLE:  job_pop  = !job_q_empty;
         BK_READ:  reading  = 1'b1;
         BK_PUSH:  rsp_push = !rsp_full;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      job_in  = job_ff;
      dr_in   = dr_ff;
      dc_in   = dc_ff;
      vld_in  = 1'b0;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      // read data lands in the cycle after its address
      if (vld_ff) begin
         for (int c = 0; c < 3; c++) begin
            acc_in[c] = acc_ff[c] + SUM_W'(rd_ch[c]);
         end
      end
      case (state_ff)
         BK_IDLE: begin
            job_in = job_q_data;
            dr_in  = '0;
            dc_in  = '0;
            acc_in = '0;
         end
         BK_READ: begin
            vld_in = row_ok && col_ok;
            if (dc_ff == span_last) begin
               dc_in = '0;
               dr_in = dr_ff + RIW'(1);
            end else begin
               dc_in = dc_ff + RIW'(1);
            end
         end
         BK_DRAIN: begin
            // rounded mean: (2*sum + area) / (2*area)
            for (int c = 0; c < 3; c++) begin
               rem_in[c] = REM_W'({acc_in[c], 1'b0}) + REM_W'(area);
            end
            den_in  = REM_W'(area) << DIV_STEPS;
            quo_in  = '0;
            step_in = '0;
         end
         BK_DIVIDE: begin
            for (int c = 0; c < 3; c++) begin
               if (rem_ff[c] >= den_ff) begin
                  rem_in[c] = rem_ff[c] - den_ff;
                  quo_in[c] = {quo_ff[c][6:0], 1'b1};
               end else begin
                  quo_in[c] = {quo_ff[c][6:0], 1'b0};
               end
            end
            den_in  = den_ff >> 1;
            step_in = step_ff + 3'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      dr_ff   <= dr_in;
      dc_ff   <= dc_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign rsp_item = '{red_out: quo_ff[2], green_out: quo_ff[1], blue_out: quo_ff[0],
                       last_of_frame: job_ff.last};

endmodule

### hw/rtl/rgb_box_mean_filter.sv
// top level of the rgb box mean filter
//
// Usage
//   req_*: pixel queue in. An item is taken when req_push is high and req_full low.
//     Pixels come in raster order; is_flush items pad past the frame end.
//   rsp_*: result queue out. The oldest result sits on rsp_data while rsp_empty is low
//     and leaves when rsp_pop is high.
//   csr_*: write port for radius (0), frame_width (1) and frame_height (2); any valid
//     write restarts the frame. Write only while the block is idle.
// Flow
//   Results trail inputs by radius*width+radius items; send that many flush items after
//   the last pixel. An item that yields a result needs one line store read per window
//   tap on the single read port, then an 8 step divider, then the write into the result
//   queue; no new item is taken while its window is being read.
//   A result is on rsp_data in the cycle after it enters an empty result queue.
// Reset
//   Positions clear, registers return to radius 1 and 1024x1024; the line store is not
//   cleared and needs no clearing pass.
// Stall
//   When nobody pops, two results queue up and the back end then waits; the front end
//   raises req_full while a window job is pending or a window is being read.
module rgb_box_mean_filter #(
   parameter int MAX_RADIUS = 7,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bmf_pkg::req_type  req_data,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output bmf_pkg::rsp_type  rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [10:0]       csr_wdata
);

   import bmf_pkg::*;

   localparam int RB     = $clog2(2 * MAX_RADIUS + 2);
   localparam int CB     = $clog2(MAX_WIDTH);
   localparam int ADDR_W = RB + CB;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [2:0]             radius_ff, radius_in;
   logic [10:0]            width_ff, width_in, height_ff, height_in;
   logic                   restart;
   cfg_type                cfg;
   logic                   st_we;
   logic [ADDR_W-1:0]      st_addr, rd_addr;
   pixel_type              st_data, rd_data;
   logic                   job_push, job_pop, job_q_empty, job_q_full;
   job_type                job, job_q_data;
   logic                   rsp_push, rsp_q_full, bk_reading;
   rsp_type                rsp_item;
   logic [$bits(rsp_type)-1:0] rsp_vec;

   // configuration registers
   always_comb begin
      radius_in = radius_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RADIUS: radius_in = csr_wdata[2:0];
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RST_RADIUS;
         width_ff  <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
      end else begin
         radius_ff <= radius_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign restart = csr_we && (csr_index == CSR_RADIUS || csr_index == CSR_WIDTH ||
                               csr_index == CSR_HEIGHT);

   // clamp into the supported range
   assign cfg.radius = (32'(radius_ff) > MAX_RADIUS) ? 3'(MAX_RADIUS) : radius_ff;
   assign cfg.width  = (width_ff == '0) ? 11'd1 :
                       ((32'(width_ff) > MAX_WIDTH) ? 11'(MAX_WIDTH) : width_ff);
   assign cfg.height = (height_ff == '0) ? 11'd1 :
                       ((32'(height_ff) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : height_ff);

   // front end
   bmf_front #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .restart      (restart),
      .push         (req_push),
      .full         (req_full),
      .item         (req_data),
      .job_q_empty  (job_q_empty),
      .back_reading (bk_reading),
      .st_we        (st_we),
      .st_addr      (st_addr),
      .st_data      (st_data),
      .job_push     (job_push),
      .job          (job)
   );

   // line store
   bmf_ram #(
      .WIDTH  ($bits(pixel_type)),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock (clock),
      .we    (st_we),
      .waddr (st_addr),
      .wdata (st_data),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   // job queue between front and back
   bmf_fifo #(
      .WIDTH ($bits(job_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_job_q (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .full    (job_q_full),
      .wr_data (job),
      .pop     (job_pop),
      .empty   (job_q_empty),
      .rd_data (job_q_data)
   );

   // back end
   bmf_back #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .job_q_empty (job_q_empty),
      .job_q_data  (job_q_data),
      .job_pop     (job_pop),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .rsp_full    (rsp_q_full),
      .rsp_push    (rsp_push),
      .rsp_item    (rsp_item),
      .reading     (bk_reading)
   );

   // result queue
   bmf_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .full    (rsp_q_full),
      .wr_data (rsp_item),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (rsp_vec)
   );

   assign rsp_data = rsp_type'(rsp_vec);

`ifndef SYNTHESIS
   // the store must not change under a window walk
   a_store_quiet: assert property (@(posedge clock) disable iff (reset)
      st_we |-> !bk_reading)
      else $error("line store written during window read");

   // at most one job outstanding, so the queue never fills
   a_job_single: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_q_empty && !job_q_full))
      else $error("job issued while another job waits");

   // a fresh job holds off the next item
   a_hold_after_job: assert property (@(posedge clock) disable iff (reset)
      job_push |=> req_full)
      else $error("input taken right after a job was issued");
`endif

endmodule

### test/tb_rgb_box_mean_filter.sv
// self-checking testbench for the rgb box mean filter
`timescale 1ns / 1ps

module tb_rgb_box_mean_filter;
   import bmf_pkg::*;

   localparam int MAX_R = 7;
   localparam int MAX_W = 1024;
   localparam int MAX_H = 1024;
   localparam int STORE_DEPTH = 2 * MAX_R * MAX_W + 2 * MAX_R + 1;
   localparam int WATCHDOG_LIMIT = 20000;
   // index beyond the register list
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   req_type req_data;
   logic rsp_pop;
   logic rsp_empty;
   rsp_type rsp_data;
   logic csr_we;
   logic [1:0] csr_index;
   logic [10:0] csr_wdata;

   // predictor state
   logic [23:0] pixel_mem [STORE_DEPTH];
   int unsigned win_radius, img_width, img_height, row_pos, col_pos;
   rsp_type filtered_q[$];
   int unsigned mismatch_count;
   int unsigned idle_cycles;
   int unsigned pop_hold;
   bit calm_mode;

   rgb_box_mean_filter dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_pop(rsp_pop), .rsp_empty(rsp_empty), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   function automatic int unsigned clamp_val(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // register write on the predictor side
   function automatic void model_csr(input logic [1:0] idx, input logic [10:0] val);
      case (idx)
         CSR_RADIUS: win_radius = val[2:0];
         CSR_WIDTH: img_width = val;
         CSR_HEIGHT: img_height = val;
         default: return;
      endcase
      row_pos = 0;
      col_pos = 0;
   endfunction

   // box mean of one item, pushes an expectation when a window completes
   function automatic void predict_mean(input req_type item);
      int unsigned r, w, h, total, lag, p, q, qr, qc, area;
      int unsigned sr, sg, sb;
      int yr, yc;
      logic [23:0] v;
      rsp_type res;
      r = (win_radius > MAX_R) ? MAX_R : win_radius;
      w = clamp_val(img_width, 1, MAX_W);
      h = clamp_val(img_height, 1, MAX_H);
      total = w * h;
      lag = r * w + r;
      sr = 0;
      sg = 0;
      sb = 0;
      if (col_pos >= w) col_pos = 0;
      p = row_pos * w + col_pos;
      if (p < total)
         pixel_mem[p % STORE_DEPTH] = item.is_flush ? 24'd0 :
                                      {item.red_in, item.green_in, item.blue_in};
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (p < lag) return;
      q = p - lag;
      if (q >= total) begin
         row_pos = 0;
         col_pos = 0;
         return;
      end
      qr = q / w;
      qc = q % w;
      for (int dr = -int'(r); dr <= int'(r); dr++) begin
         yr = int'(qr) + dr;
         if (yr < 0 || yr >= int'(h)) continue;
         for (int dc = -int'(r); dc <= int'(r); dc++) begin
            yc = int'(qc) + dc;
            if (yc < 0 || yc >= int'(w)) continue;
            v = pixel_mem[(yr * w + yc) % STORE_DEPTH];
            sr += v[23:16];
            sg += v[15:8];
            sb += v[7:0];
         end
      end
      area = (2 * r + 1) * (2 * r + 1);
      res.red_out = 8'((2 * sr + area) / (2 * area));
      res.green_out = 8'((2 * sg + area) / (2 * area));
      res.blue_out = 8'((2 * sb + area) / (2 * area));
      res.last_of_frame = (q == total - 1);
      if (res.last_of_frame) begin
         row_pos = 0;
         col_pos = 0;
      end
      filtered_q.push_back(res);
   endfunction

   // send one item, at times after a random gap (never in calm mode); push stays high until the caller idles
   task automatic send_item(input req_type item);
      if (!calm_mode && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_mean(item);
   endtask

   function automatic req_type rand_pixel(input bit flush);
      req_type item;
      item.red_in = 8'($urandom);
      item.green_in = 8'($urandom);
      item.blue_in = 8'($urandom);
      item.is_flush = flush;
      return item;
   endfunction

   // wait until all results are in, then let the block settle
   task automatic wait_drained();
      req_push <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [10:0] val);
      req_push <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      model_csr(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned r, input int unsigned w,
                               input int unsigned h);
      wait_drained();
      write_csr(CSR_RADIUS, 11'(r));
      write_csr(CSR_WIDTH, 11'(w));
      write_csr(CSR_HEIGHT, 11'(h));
   endtask

   // one frame of pixels plus the flush tail
   task automatic run_frame(input int unsigned n_pix, input int unsigned n_flush,
                            input bit fixed, input logic [7:0] level);
      req_type item;
      for (int unsigned i = 0; i < n_pix; i++) begin
         item = rand_pixel(1'b0);
         if (fixed) item = '{level, level, level, 1'b0};
         else if ($urandom_range(0, 19) == 0) item.is_flush = 1'b1;
         send_item(item);
      end
      for (int unsigned i = 0; i < n_flush; i++)
         send_item(rand_pixel(1'b1));
   endtask

   function automatic int unsigned eff_lag();
      int unsigned r, w;
      r = (win_radius > MAX_R) ? MAX_R : win_radius;
      w = clamp_val(img_width, 1, MAX_W);
      return r * w + r;
   endfunction

   function automatic int unsigned eff_total();
      return clamp_val(img_width, 1, MAX_W) * clamp_val(img_height, 1, MAX_H);
   endfunction

   // extremes of the pixel values, pass through and a single pixel frame
   task automatic test_directed();
      set_geometry(0, 3, 2);
      send_item('{8'd0, 8'd0, 8'd0, 1'b0});
      send_item('{8'd255, 8'd255, 8'd255, 1'b0});
      send_item('{8'hAA, 8'h55, 8'h0F, 1'b0});
      send_item('{8'h55, 8'hAA, 8'hF0, 1'b0});
      send_item('{8'd255, 8'd255, 8'd255, 1'b1});
      send_item('{8'd1, 8'd128, 8'd254, 1'b0});
      // all white 3x3 with radius 1, then the frame end
      set_geometry(1, 3, 3);
      run_frame(9, eff_lag(), 1'b1, 8'd255);
      // width and height of zero act as one
      set_geometry(1, 0, 0);
      send_item('{8'd200, 8'd100, 8'd50, 1'b0});
      send_item('{8'd9, 8'd9, 8'd9, 1'b0});
      // past the frame end a colored item is padding
      send_item('{8'd9, 8'd9, 8'd9, 1'b0});
      send_item('{8'd9, 8'd9, 8'd9, 1'b1});
   endtask

   // oversized registers saturate, unused index is ignored
   task automatic test_register_limits();
      set_geometry(7, 2047, 2);
      write_csr(CSR_UNUSED, 11'h7FF);
      run_frame(40, 0, 1'b0, 8'd0);
      set_geometry(7, 16, 16);
      run_frame(eff_total(), eff_lag(), 1'b0, 8'd0);
      // write in mid frame restarts it
      set_geometry(2, 5, 4);
      run_frame(7, 0, 1'b0, 8'd0);
      write_csr(CSR_RADIUS, 11'd2);
      run_frame(eff_total(), eff_lag(), 1'b0, 8'd0);
   endtask

   // random frames of small size, one at the widest row
   task automatic test_random_frames();
      int unsigned sent;
      sent = 0;
      set_geometry($urandom_range(0, 1), 1024, 1);
      sent += eff_total() + eff_lag();
      run_frame(eff_total(), eff_lag(), 1'b0, 8'd0);
      while (sent < 1200) begin
         set_geometry($urandom_range(0, 7), $urandom_range(1, 12),
                      $urandom_range(1, 12));
         sent += eff_total() + eff_lag();
         run_frame(eff_total(), eff_lag(), 1'b0, 8'd0);
         if ($urandom_range(0, 3) == 0) run_frame($urandom_range(1, 5), 0, 1'b0, 8'd0);
      end
      calm_mode = 1'b1;
      set_geometry(3, 9, 7);
      run_frame(eff_total(), eff_lag(), 1'b0, 8'd0);
   endtask

   // result side: pops with idle bursts, and checks
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_hold <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (filtered_q.size() == 0) begin
               report_mismatch("unexpected item", 32'(rsp_data), 0);
            end else begin
               want = filtered_q.pop_front();
               if (rsp_data.red_out !== want.red_out)
                  report_mismatch("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.green_out !== want.green_out)
                  report_mismatch("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.blue_out !== want.blue_out)
                  report_mismatch("blue_out", rsp_data.blue_out, want.blue_out);
               if (rsp_data.last_of_frame !== want.last_of_frame)
                  report_mismatch("last_of_frame", rsp_data.last_of_frame,
                                  want.last_of_frame);
            end
         end
         if (calm_mode) begin
            rsp_pop <= 1'b1;
         end else if (pop_hold != 0) begin
            pop_hold <= pop_hold - 1;
            rsp_pop <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            pop_hold <= $urandom_range(1, 15) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no accepted item, popped result or register write
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = CSR_RADIUS;
      csr_wdata = '0;
      calm_mode = 1'b0;
      mismatch_count = 0;
      idle_cycles = 0;
      win_radius = RST_RADIUS;
      img_width = RST_WIDTH;
      img_height = RST_HEIGHT;
      row_pos = 0;
      col_pos = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_limits();
      test_random_frames();
      wait_drained();
      if (mismatch_count == 0 && filtered_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/bmf_pkg.sv
hw/rtl/bmf_ram.sv
hw/rtl/bmf_fifo.sv
hw/rtl/bmf_front.sv
hw/rtl/bmf_back.sv
hw/rtl/rgb_box_mean_filter.sv
test/tb_rgb_box_mean_filter.sv
